@@ rtl/rotation_matrix_to_quaternion_top_defines.svh @@
// Assertion macros for the rotation matrix to quaternion block.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH

`ifndef SYNTH
`define RMQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rmq check failed");
`define RMQ_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rmq check failed");
`else
`define RMQ_ASSERT_IMP(label, clk, rstn, ante, cons)
`define RMQ_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/rmq_pkg.sv @@
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int LANES     = 3;

    localparam int RAD_W  = ((IN_W + 2 > FRAC_BITS + 1) ? IN_W + 2 : FRAC_BITS + 1) + 1;
    localparam int RADU_W = RAD_W - 1;
    localparam int N_RAW  = RADU_W + FRAC_BITS;
    localparam int N_W    = N_RAW + (N_RAW % 2);
    localparam int ROOT_W = N_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    localparam int D_W    = IN_W + 1;
    localparam int MAG_W  = IN_W + 1;
    localparam int NUM_W  = ((MAG_W + FRAC_BITS > ROOT_W) ? MAG_W + FRAC_BITS : ROOT_W) + 1;
    localparam int QB     = IN_W;
    localparam int DIV_W  = ROOT_W + 1;
    localparam int DREM_W = DIV_W + 1;
    localparam int DSTG   = QB + 1;

    localparam logic [1:0] POS_X = 2'd0;
    localparam logic [1:0] POS_Y = 2'd1;
    localparam logic [1:0] POS_Z = 2'd2;
    localparam logic [1:0] POS_W = 2'd3;

    localparam logic signed [IN_W-1:0] SMAX = {1'b0, {(IN_W-1){1'b1}}};
    localparam logic signed [IN_W-1:0] SMIN = {1'b1, {(IN_W-1){1'b0}}};

    typedef logic signed [D_W-1:0] diff_t;

    typedef struct packed {
        logic signed [IN_W-1:0] m00;
        logic signed [IN_W-1:0] m01;
        logic signed [IN_W-1:0] m02;
        logic signed [IN_W-1:0] m10;
        logic signed [IN_W-1:0] m11;
        logic signed [IN_W-1:0] m12;
        logic signed [IN_W-1:0] m20;
        logic signed [IN_W-1:0] m21;
        logic signed [IN_W-1:0] m22;
    } in_item_t;

    typedef struct packed {
        logic signed [IN_W-1:0] quat_x;
        logic signed [IN_W-1:0] quat_y;
        logic signed [IN_W-1:0] quat_z;
        logic signed [IN_W-1:0] quat_w;
        logic                   radicand_bad;
    } out_item_t;

    typedef struct packed {
        logic [1:0]             lpos;
        diff_t [LANES-1:0]      num;
        logic                   bad;
    } ctx_t;

    typedef struct packed {
        logic            neg;
        logic            ov;
        logic [QB-1:0]   q;
    } div_res_t;

    function automatic logic signed [IN_W-1:0] sat_quot(input div_res_t r);
        logic signed [IN_W-1:0] res;
        if (!r.neg) begin
            if (r.ov || (r.q > $unsigned(SMAX))) res = SMAX;
            else res = signed'(r.q);
        end else begin
            if (r.ov || (r.q > $unsigned(SMIN))) res = SMIN;
            else res = signed'(IN_W'(QB'(0) - r.q));
        end
        return res;
    endfunction

    function automatic logic signed [IN_W-1:0] sat_major(input logic [ROOT_W-1:0] s);
        logic [ROOT_W:0] h;
        h = ({1'b0, s} + (ROOT_W+1)'(1)) >> 1;
        if (h > (ROOT_W+1)'($unsigned(SMAX))) return SMAX;
        return signed'(IN_W'(h));
    endfunction

endpackage

@@ rtl/rmq_prep.sv @@
module rmq_prep (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  rmq_pkg::in_item_t            in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rmq_pkg::RADU_W-1:0]   out_rad,
    output rmq_pkg::ctx_t                out_ctx
);
    import rmq_pkg::*;

    logic signed [RAD_W-1:0] e00, e11, e22, trace, rad;
    logic [RADU_W-1:0]       rad_next, rad_reg;
    ctx_t                    ctx_next, ctx_reg;
    logic                    vld_next, vld_reg;
    logic                    go;

    assign e00   = RAD_W'(in_item.m00);
    assign e11   = RAD_W'(in_item.m11);
    assign e22   = RAD_W'(in_item.m22);
    assign trace = e00 + e11 + e22;

    always_comb begin
        ctx_next.bad = 1'b0;
        if (trace > 0) begin
            ctx_next.lpos   = POS_W;
            rad             = trace + RAD_W'(ONE);
            ctx_next.num[0] = D_W'(in_item.m21) - D_W'(in_item.m12);
            ctx_next.num[1] = D_W'(in_item.m02) - D_W'(in_item.m20);
            ctx_next.num[2] = D_W'(in_item.m10) - D_W'(in_item.m01);
        end else if ((in_item.m00 < in_item.m11) && !(in_item.m11 < in_item.m22)) begin
            ctx_next.lpos   = POS_Y;
            rad             = e11 - e22 - e00 + RAD_W'(ONE);
            ctx_next.num[0] = D_W'(in_item.m01) + D_W'(in_item.m10);
            ctx_next.num[1] = D_W'(in_item.m21) + D_W'(in_item.m12);
            ctx_next.num[2] = D_W'(in_item.m02) - D_W'(in_item.m20);
        end else if ((in_item.m00 < in_item.m11) || (in_item.m00 < in_item.m22)) begin
            ctx_next.lpos   = POS_Z;
            rad             = e22 - e00 - e11 + RAD_W'(ONE);
            ctx_next.num[0] = D_W'(in_item.m02) + D_W'(in_item.m20);
            ctx_next.num[1] = D_W'(in_item.m12) + D_W'(in_item.m21);
            ctx_next.num[2] = D_W'(in_item.m10) - D_W'(in_item.m01);
        end else begin
            ctx_next.lpos   = POS_X;
            rad             = e00 - e11 - e22 + RAD_W'(ONE);
            ctx_next.num[0] = D_W'(in_item.m10) + D_W'(in_item.m01);
            ctx_next.num[1] = D_W'(in_item.m20) + D_W'(in_item.m02);
            ctx_next.num[2] = D_W'(in_item.m21) - D_W'(in_item.m12);
        end
        if (rad < 1) begin
            ctx_next.bad = 1'b1;
            rad_next     = RADU_W'(1);
        end else begin
            rad_next     = rad[RADU_W-1:0];
        end
    end

    assign go       = !vld_reg || out_ready;
    assign in_ready = go;
    assign vld_next = go ? in_valid : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            rad_reg <= rad_next;
            ctx_reg <= ctx_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_rad   = rad_reg;
    assign out_ctx   = ctx_reg;

endmodule

@@ rtl/rmq_sqrt.sv @@
module rmq_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rmq_pkg::RADU_W-1:0]   in_rad,
    input  rmq_pkg::ctx_t                in_ctx,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rmq_pkg::ROOT_W-1:0]   out_root,
    output rmq_pkg::ctx_t                out_ctx
);
    import rmq_pkg::*;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [N_W-1:0]    n;
        ctx_t              ctx;
    } sq_t;

    sq_t               st_reg  [ROOT_W];
    sq_t               st_next [ROOT_W];
    logic [ROOT_W-1:0] vld_reg, vld_next;
    logic [ROOT_W:0]   go;

    always_comb begin
        go[ROOT_W] = out_ready;
        for (int s = ROOT_W - 1; s >= 0; s--) begin
            go[s] = !vld_reg[s] || go[s+1];
        end
    end

    always_comb begin
        sq_t              src;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        for (int s = 0; s < ROOT_W; s++) begin
            if (s == 0) begin
                src.rem  = '0;
                src.root = '0;
                src.n    = N_W'(in_rad) << FRAC_BITS;
                src.ctx  = in_ctx;
                vld_next[s] = go[s] ? in_valid : vld_reg[s];
            end else begin
                src = st_reg[s-1];
                vld_next[s] = go[s] ? vld_reg[s-1] : vld_reg[s];
            end
            rem_sh = {src.rem[REM_W-3:0], src.n[N_W-1 -: 2]};
            trial  = {src.root, 2'b01};
            st_next[s]     = src;
            st_next[s].n   = src.n << 2;
            if (rem_sh >= trial) begin
                st_next[s].rem  = rem_sh - trial;
                st_next[s].root = {src.root[ROOT_W-2:0], 1'b1};
            end else begin
                st_next[s].rem  = rem_sh;
                st_next[s].root = {src.root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < ROOT_W; s++) begin
            if (go[s]) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign in_ready  = go[0];
    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = st_reg[ROOT_W-1].root;
    assign out_ctx   = st_reg[ROOT_W-1].ctx;

endmodule

@@ rtl/rmq_div.sv @@
module rmq_div (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [rmq_pkg::ROOT_W-1:0]             in_root,
    input  rmq_pkg::ctx_t                          in_ctx,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [rmq_pkg::IN_W-1:0]        out_major,
    output rmq_pkg::div_res_t [rmq_pkg::LANES-1:0] out_res,
    output rmq_pkg::ctx_t                          out_ctx
);
    import rmq_pkg::*;

    typedef struct packed {
        logic              neg;
        logic              ov;
        logic [DREM_W-1:0] rem;
        logic [QB-1:0]     nq;
    } lane_t;

    typedef struct packed {
        logic [DIV_W-1:0]       dvs;
        logic signed [IN_W-1:0] major;
        lane_t [LANES-1:0]      lane;
        ctx_t                   ctx;
    } dv_t;

    dv_t             st_reg  [DSTG];
    dv_t             st_next [DSTG];
    logic [DSTG-1:0] vld_reg, vld_next;
    logic [DSTG:0]   go;

    always_comb begin
        go[DSTG] = out_ready;
        for (int s = DSTG - 1; s >= 0; s--) begin
            go[s] = !vld_reg[s] || go[s+1];
        end
    end

    always_comb begin
        diff_t             d;
        logic [MAG_W-1:0]  mag;
        logic [NUM_W-1:0]  num;
        logic [DREM_W-1:0] rem_sh;
        dv_t               src;

        st_next[0].dvs   = {in_root, 1'b0};
        st_next[0].major = sat_major(in_root);
        st_next[0].ctx   = in_ctx;
        for (int l = 0; l < LANES; l++) begin
            d   = in_ctx.num[l];
            mag = (d < 0) ? $unsigned(-d) : $unsigned(d);
            num = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(in_root);
            st_next[0].lane[l].neg = (d < 0);
            st_next[0].lane[l].ov  = (DIV_W'(num[NUM_W-1:QB]) >= st_next[0].dvs);
            st_next[0].lane[l].rem = st_next[0].lane[l].ov ? '0 :
                                     DREM_W'(num[NUM_W-1:QB]);
            st_next[0].lane[l].nq  = num[QB-1:0];
        end
        vld_next[0] = go[0] ? in_valid : vld_reg[0];

        for (int s = 1; s < DSTG; s++) begin
            src = st_reg[s-1];
            st_next[s] = src;
            for (int l = 0; l < LANES; l++) begin
                rem_sh = {src.lane[l].rem[DREM_W-2:0], src.lane[l].nq[QB-1]};
                if (rem_sh >= DREM_W'(src.dvs)) begin
                    st_next[s].lane[l].rem = rem_sh - DREM_W'(src.dvs);
                    st_next[s].lane[l].nq  = {src.lane[l].nq[QB-2:0], 1'b1};
                end else begin
                    st_next[s].lane[l].rem = rem_sh;
                    st_next[s].lane[l].nq  = {src.lane[l].nq[QB-2:0], 1'b0};
                end
            end
            vld_next[s] = go[s] ? vld_reg[s-1] : vld_reg[s];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < DSTG; s++) begin
            if (go[s]) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            out_res[l].neg = st_reg[DSTG-1].lane[l].neg;
            out_res[l].ov  = st_reg[DSTG-1].lane[l].ov;
            out_res[l].q   = st_reg[DSTG-1].lane[l].nq;
        end
    end

    assign in_ready  = go[0];
    assign out_valid = vld_reg[DSTG-1];
    assign out_major = st_reg[DSTG-1].major;
    assign out_ctx   = st_reg[DSTG-1].ctx;

endmodule

@@ rtl/rotation_matrix_to_quaternion_top.sv @@
// Rotation matrix to unit quaternion, signed Q2.14 in and out.
// Input channel s_valid/s_ready/s_item carries the nine matrix entries;
// result channel m_valid/m_ready/m_item carries quat_x/y/z/w and
// radicand_bad, the flag for a clamped square root radicand.
// Each item yields exactly one result, in order.
// From acceptance to m_valid an item passes the prep register for trace,
// branch choice and numerators, the square root stages (one root bit
// per stage), the divider stages for the three lanes (range check, then
// one quotient bit per stage) and one output register.
// One item per cycle while m_ready is high; every stage is a register stage.
// When m_ready is low the result holds in the output register and the
// stages behind it keep filling their empty slots, so s_ready stays high
// until the whole pipeline is full.
// Reset (aresetn low, synchronous) clears all valid bits; in-flight items
// are dropped and the block takes a new item in the first cycle after.
`include "rotation_matrix_to_quaternion_top_defines.svh"

module rotation_matrix_to_quaternion_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rmq_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output rmq_pkg::out_item_t  m_item
);
    import rmq_pkg::*;

    logic                   prep_valid, prep_ready;
    logic [RADU_W-1:0]      prep_rad;
    ctx_t                   prep_ctx;
    logic                   sq_valid, sq_ready;
    logic [ROOT_W-1:0]      sq_root;
    ctx_t                   sq_ctx;
    logic                   div_valid, div_ready;
    logic signed [IN_W-1:0] div_major;
    div_res_t [LANES-1:0]   div_res;
    ctx_t                   div_ctx;

    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_item_reg, m_item_next;
    logic signed [IN_W-1:0] v0, v1, v2;

    rmq_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_rad   (prep_rad),
        .out_ctx   (prep_ctx)
    );

    rmq_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_rad    (prep_rad),
        .in_ctx    (prep_ctx),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_root  (sq_root),
        .out_ctx   (sq_ctx)
    );

    rmq_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .in_root   (sq_root),
        .in_ctx    (sq_ctx),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_major (div_major),
        .out_res   (div_res),
        .out_ctx   (div_ctx)
    );

    assign v0 = sat_quot(div_res[0]);
    assign v1 = sat_quot(div_res[1]);
    assign v2 = sat_quot(div_res[2]);

    always_comb begin
        m_item_next.radicand_bad = div_ctx.bad;
        unique case (div_ctx.lpos)
            POS_X: begin
                m_item_next.quat_x = div_major;
                m_item_next.quat_y = v0;
                m_item_next.quat_z = v1;
                m_item_next.quat_w = v2;
            end
            POS_Y: begin
                m_item_next.quat_x = v0;
                m_item_next.quat_y = div_major;
                m_item_next.quat_z = v1;
                m_item_next.quat_w = v2;
            end
            POS_Z: begin
                m_item_next.quat_x = v0;
                m_item_next.quat_y = v1;
                m_item_next.quat_z = div_major;
                m_item_next.quat_w = v2;
            end
            POS_W: begin
                m_item_next.quat_x = v0;
                m_item_next.quat_y = v1;
                m_item_next.quat_z = v2;
                m_item_next.quat_w = div_major;
            end
        endcase
    end

    assign div_ready    = !m_valid_reg || m_ready;
    assign m_valid_next = div_ready ? div_valid : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_ready) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `RMQ_ASSERT_IMP(a_bad_not_trace, aclk, aresetn, div_valid && div_ctx.bad, div_ctx.lpos != POS_W)
    `RMQ_ASSERT_IMP(a_major_nonneg, aclk, aresetn, div_valid, !div_major[IN_W-1])
    `RMQ_ASSERT_NXT(a_div_to_out, aclk, aresetn, div_valid && div_ready, m_valid_reg)

endmodule
